// ===== src/serm_pkg.sv =====
// shared types, constants and helpers for the exponential-ramp stepper move block
package serm_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int RATIO_FRAC = 16;
   localparam int ACC_W      = 16 + FRAC_BITS;
   localparam int RATIO_W    = 17;
   localparam int PROD_W     = ACC_W + RATIO_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_MOVE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_UP_STEPS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_DOWN_STEPS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HALF_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HALF_PERIOD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_RATIO     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL_RATIO     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS    = 3'd7;

   // register reset values
   localparam logic [15:0] RST_STEPS_PER_MOVE  = 16'd400;
   localparam logic [15:0] RST_RAMP_UP_STEPS   = 16'd92;
   localparam logic [15:0] RST_RAMP_DOWN_STEPS = 16'd92;
   localparam logic [15:0] RST_MIN_HALF_PERIOD = 16'd119;
   localparam logic [15:0] RST_MAX_HALF_PERIOD = 16'd957;
   localparam logic [15:0] RST_ACCEL_RATIO     = 16'd64068;
   localparam logic [16:0] RST_DECEL_RATIO     = 17'd67038;
   localparam logic [23:0] RST_SETTLE_TICKS    = 24'd20000;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_MOVE   = 4'b0010,
      PH_SETTLE = 4'b0100,
      PH_HALT   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic kind;
      logic position_ok;
   } req_type;

   typedef struct packed {
      logic step_level;
      logic busy_res;
      logic ready_res;
      logic alarm;
   } rsp_type;

   typedef struct packed {
      logic [15:0] steps_per_move;
      logic [15:0] ramp_up_steps;
      logic [15:0] ramp_down_steps;
      logic [15:0] min_half_period;
      logic [15:0] max_half_period;
      logic [15:0] accel_ratio;
      logic [16:0] decel_ratio;
      logic [23:0] settle_ticks;
   } cfg_type;

   // accumulators as seen by the product stage
   typedef struct packed {
      logic [ACC_W-1:0] accel_period;
      logic [ACC_W-1:0] decel_period;
   } acc_type;

   // precomputed next values of the accumulators
   typedef struct packed {
      logic [ACC_W-1:0] accel_scaled;
      logic [ACC_W-1:0] decel_scaled;
      logic [ACC_W-1:0] accel_start;
      logic [ACC_W-1:0] decel_start;
   } prod_type;

   // acc * ratio >> 16, saturated to the accumulator width
   function automatic logic [ACC_W-1:0] scale(input logic [ACC_W-1:0] acc,
                                              input logic [RATIO_W-1:0] ratio);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] shifted;
      prod    = PROD_W'(acc) * PROD_W'(ratio);
      shifted = prod >> RATIO_FRAC;
      if (shifted > PROD_W'(ACC_MAX))
         scale = ACC_MAX;
      else
         scale = shifted[ACC_W-1:0];
   endfunction

endpackage

// ===== src/serm_csr.sv =====
// configuration register file
module serm_csr
   import serm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEPS_PER_MOVE:  cfg_in.steps_per_move  = csr_wdata[15:0];
            CSR_RAMP_UP_STEPS:   cfg_in.ramp_up_steps   = csr_wdata[15:0];
            CSR_RAMP_DOWN_STEPS: cfg_in.ramp_down_steps = csr_wdata[15:0];
            CSR_MIN_HALF_PERIOD: cfg_in.min_half_period = csr_wdata[15:0];
            CSR_MAX_HALF_PERIOD: cfg_in.max_half_period = csr_wdata[15:0];
            CSR_ACCEL_RATIO:     cfg_in.accel_ratio     = csr_wdata[15:0];
            CSR_DECEL_RATIO:     cfg_in.decel_ratio     = csr_wdata[16:0];
            CSR_SETTLE_TICKS:    cfg_in.settle_ticks    = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_move  <= RST_STEPS_PER_MOVE;
         cfg_ff.ramp_up_steps   <= RST_RAMP_UP_STEPS;
         cfg_ff.ramp_down_steps <= RST_RAMP_DOWN_STEPS;
         cfg_ff.min_half_period <= RST_MIN_HALF_PERIOD;
         cfg_ff.max_half_period <= RST_MAX_HALF_PERIOD;
         cfg_ff.accel_ratio     <= RST_ACCEL_RATIO;
         cfg_ff.decel_ratio     <= RST_DECEL_RATIO;
         cfg_ff.settle_ticks    <= RST_SETTLE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/serm_scale.sv =====
// registered ratio multipliers that precompute the next accumulator values
module serm_scale
   import serm_pkg::*;
(
   input  logic     clock,
   input  cfg_type  cfg,
   input  acc_type  acc,
   output prod_type prod
);

   prod_type prod_ff;
   prod_type prod_in;

   assign prod = prod_ff;

   always_comb begin
      prod_in.accel_scaled = scale(acc.accel_period, RATIO_W'(cfg.accel_ratio));
      prod_in.decel_scaled = scale(acc.decel_period, cfg.decel_ratio);
      // first scaling after a start, from the start values
      prod_in.accel_start  = scale({cfg.max_half_period, {FRAC_BITS{1'b0}}},
                                   RATIO_W'(cfg.accel_ratio));
      prod_in.decel_start  = scale({cfg.min_half_period, {FRAC_BITS{1'b0}}},
                                   cfg.decel_ratio);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== src/serm_core.sv =====
// move state and per-request update of pulse timing, ramp and settle
module serm_core
   import serm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  req_type  item,
   input  cfg_type  cfg,
   input  prod_type prod,
   output acc_type  acc,
   output rsp_type  result
);

   phase_type        phase_ff,   phase_in;
   logic             pulse_ff,   pulse_in;
   logic [15:0]      step_ff,    step_in;
   logic [15:0]      elapsed_ff, elapsed_in;
   logic [ACC_W-1:0] accel_ff,   accel_in;
   logic [ACC_W-1:0] decel_ff,   decel_in;
   logic [23:0]      settle_ff,  settle_in;
   logic             ready_ff,   ready_in;
   logic             alarm_ff,   alarm_in;
   logic             upd_ff,     upd_in;

   logic [15:0]      hp_raw;
   logic [15:0]      half_period;
   logic [16:0]      step_plus_dec;
   logic [15:0]      elapsed_inc;
   logic [15:0]      step_next;
   logic [23:0]      settle_inc;
   logic [ACC_W-1:0] accel_next;
   logic [ACC_W-1:0] decel_next;

   assign acc.accel_period = accel_ff;
   assign acc.decel_period = decel_ff;

   always_comb begin
      step_plus_dec = {1'b0, step_ff} + {1'b0, cfg.ramp_down_steps};
      if (step_ff < cfg.ramp_up_steps)
         hp_raw = accel_ff[ACC_W-1:FRAC_BITS];
      else if (step_plus_dec < {1'b0, cfg.steps_per_move})
         hp_raw = cfg.min_half_period;
      else
         hp_raw = decel_ff[ACC_W-1:FRAC_BITS];
      if (hp_raw < cfg.min_half_period)
         half_period = cfg.min_half_period;
      else if (hp_raw > cfg.max_half_period)
         half_period = cfg.max_half_period;
      else
         half_period = hp_raw;

      elapsed_inc = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
      settle_inc  = (settle_ff != 24'hFFFFFF) ? settle_ff + 24'd1 : settle_ff;
      step_next   = step_ff + 16'd1;
      // products lag the accumulators through the product register; right after a start use the start products
      accel_next  = upd_ff ? prod.accel_start : prod.accel_scaled;
      decel_next  = upd_ff ? prod.decel_start : prod.decel_scaled;
   end

   always_comb begin
      phase_in   = phase_ff;
      pulse_in   = pulse_ff;
      step_in    = step_ff;
      elapsed_in = elapsed_ff;
      accel_in   = accel_ff;
      decel_in   = decel_ff;
      settle_in  = settle_ff;
      ready_in   = ready_ff;
      alarm_in   = alarm_ff;
      upd_in     = 1'b0;
      if (advance) begin
         if (item.kind == KIND_START) begin
            if (phase_ff == PH_IDLE) begin
               ready_in   = 1'b0;
               step_in    = '0;
               elapsed_in = '0;
               settle_in  = '0;
               accel_in   = {cfg.max_half_period, {FRAC_BITS{1'b0}}};
               decel_in   = {cfg.min_half_period, {FRAC_BITS{1'b0}}};
               upd_in     = 1'b1;
               if (cfg.steps_per_move == 16'd0) begin
                  pulse_in = 1'b0;
                  phase_in = PH_SETTLE;
               end else begin
                  pulse_in = 1'b1;
                  phase_in = PH_MOVE;
               end
            end
         end else begin
            case (phase_ff)
               PH_MOVE: begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= half_period) begin
                     elapsed_in = '0;
                     if (!pulse_ff) begin
                        pulse_in = 1'b1;
                     end else begin
                        // falling edge ends one step
                        pulse_in = 1'b0;
                        upd_in   = 1'b1;
                        if (step_ff < cfg.ramp_up_steps)
                           accel_in = accel_next;
                        if (step_plus_dec >= {1'b0, cfg.steps_per_move})
                           decel_in = decel_next;
                        step_in = step_next;
                        if (step_next >= cfg.steps_per_move) begin
                           phase_in  = PH_SETTLE;
                           settle_in = '0;
                        end
                     end
                  end
               end
               PH_SETTLE: begin
                  settle_in = settle_inc;
                  if (settle_inc >= cfg.settle_ticks) begin
                     if (item.position_ok) begin
                        ready_in = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        alarm_in = 1'b1;
                        ready_in = 1'b0;
                        phase_in = PH_HALT;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      result.step_level = pulse_in;
      result.busy_res   = (phase_in == PH_MOVE) || (phase_in == PH_SETTLE);
      result.ready_res  = ready_in;
      result.alarm      = alarm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pulse_ff   <= 1'b0;
         step_ff    <= '0;
         elapsed_ff <= '0;
         accel_ff   <= '0;
         decel_ff   <= '0;
         settle_ff  <= '0;
         ready_ff   <= 1'b0;
         alarm_ff   <= 1'b0;
         upd_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pulse_ff   <= pulse_in;
         step_ff    <= step_in;
         elapsed_ff <= elapsed_in;
         accel_ff   <= accel_in;
         decel_ff   <= decel_in;
         settle_ff  <= settle_in;
         ready_ff   <= ready_in;
         alarm_ff   <= alarm_in;
         upd_ff     <= upd_in;
      end
   end

endmodule

// ===== src/stepper_exponential_ramp_move_top.sv =====
// a request passes the input register, then the response register, before rsp_valid
// throughput: one request per cycle while rsp_stall is low, limited by the state update in serm_core
// configuration writes complete in the cycle they are presented (csr_ready is always high)
// synchronous reset clears the move state and flags and restores register defaults
// while rsp_stall is high the input register holds one more request, then req_stall rises
module stepper_exponential_ramp_move_top
   import serm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic     in_valid_ff;
   req_type  in_data_ff;
   logic     out_valid_ff;
   rsp_type  out_data_ff;
   logic     advance;
   cfg_type  cfg;
   acc_type  acc;
   prod_type prod;
   rsp_type  result;

   // request moves on when the response register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   serm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   serm_scale u_scale (
      .clock (clock),
      .cfg   (cfg),
      .acc   (acc),
      .prod  (prod)
   );

   serm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .prod    (prod),
      .acc     (acc),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall)
            in_valid_ff <= req_valid;
         if (advance)
            out_valid_ff <= 1'b1;
         else if (!rsp_stall)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall)
         in_data_ff <= req_data;
      if (advance)
         out_data_ff <= result;
   end

   a_ready_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.ready_res && rsp_data.busy_res))
      else $error("ready reported during a move");

   a_alarm_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alarm |-> !rsp_data.busy_res && !rsp_data.ready_res)
      else $error("alarm reported while busy or ready");

   a_step_in_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_level |-> rsp_data.busy_res)
      else $error("step output high outside a move");

   a_drain_frees_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_stall |-> !req_stall)
      else $error("request held although the response side drains");

endmodule

// ===== test/ramp_move_checker.sv =====
// checker for the ramp move block: predicts every response and compares it field by field
`timescale 1ns / 100ps

module ramp_move_checker
   import serm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending,
   output int                    checked,
   output logic                  move_busy,
   output logic                  sample_due
);

   cfg_type          cfg;
   phase_type        mv_phase;
   logic             pulse;
   logic [15:0]      step_no;
   logic [15:0]      tick_count;
   logic [ACC_W-1:0] accel_acc;
   logic [ACC_W-1:0] decel_acc;
   logic [23:0]      settle_count;
   logic             ready_flag;
   logic             alarm_flag;

   rsp_type expected_status[$];
   rsp_type oldest;

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   assign move_busy  = (mv_phase == PH_MOVE) || (mv_phase == PH_SETTLE);
   // the next tick in settle is the one that samples the position input
   assign sample_due = (mv_phase == PH_SETTLE) &&
                       (25'(settle_count) + 25'd1 >= 25'(cfg.settle_ticks));

   function automatic logic [ACC_W-1:0] ratio_mult(input logic [ACC_W-1:0] acc,
                                                   input logic [16:0] ratio);
      logic [63:0] full;
      full = (64'(acc) * 64'(ratio)) >> 16;
      return (full > 64'(ACC_MAX)) ? ACC_MAX : full[ACC_W-1:0];
   endfunction

   function automatic logic [15:0] step_half_period();
      logic [31:0] v;
      if (step_no < cfg.ramp_up_steps)
         v = 32'(accel_acc >> FRAC_BITS);
      else if (17'(step_no) + 17'(cfg.ramp_down_steps) < 17'(cfg.steps_per_move))
         v = 32'(cfg.min_half_period);
      else
         v = 32'(decel_acc >> FRAC_BITS);
      if (v < 32'(cfg.min_half_period))
         v = 32'(cfg.min_half_period);
      else if (v > 32'(cfg.max_half_period))
         v = 32'(cfg.max_half_period);
      return v[15:0];
   endfunction

   task automatic restore_defaults();
      cfg.steps_per_move  = RST_STEPS_PER_MOVE;
      cfg.ramp_up_steps   = RST_RAMP_UP_STEPS;
      cfg.ramp_down_steps = RST_RAMP_DOWN_STEPS;
      cfg.min_half_period = RST_MIN_HALF_PERIOD;
      cfg.max_half_period = RST_MAX_HALF_PERIOD;
      cfg.accel_ratio     = RST_ACCEL_RATIO;
      cfg.decel_ratio     = RST_DECEL_RATIO;
      cfg.settle_ticks    = RST_SETTLE_TICKS;
      mv_phase     = PH_IDLE;
      pulse        = 1'b0;
      step_no      = '0;
      tick_count   = '0;
      accel_acc    = '0;
      decel_acc    = '0;
      settle_count = '0;
      ready_flag   = 1'b0;
      alarm_flag   = 1'b0;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_STEPS_PER_MOVE:  cfg.steps_per_move  = data[15:0];
         CSR_RAMP_UP_STEPS:   cfg.ramp_up_steps   = data[15:0];
         CSR_RAMP_DOWN_STEPS: cfg.ramp_down_steps = data[15:0];
         CSR_MIN_HALF_PERIOD: cfg.min_half_period = data[15:0];
         CSR_MAX_HALF_PERIOD: cfg.max_half_period = data[15:0];
         CSR_ACCEL_RATIO:     cfg.accel_ratio     = data[15:0];
         CSR_DECEL_RATIO:     cfg.decel_ratio     = data[16:0];
         CSR_SETTLE_TICKS:    cfg.settle_ticks    = data[23:0];
         default: ;
      endcase
   endtask

   task automatic advance_motion(input req_type r);
      if (r.kind == KIND_START) begin
         if (mv_phase == PH_IDLE) begin
            ready_flag   = 1'b0;
            step_no      = '0;
            tick_count   = '0;
            settle_count = '0;
            accel_acc    = ACC_W'(cfg.max_half_period) << FRAC_BITS;
            decel_acc    = ACC_W'(cfg.min_half_period) << FRAC_BITS;
            if (cfg.steps_per_move == 16'd0) begin
               pulse    = 1'b0;
               mv_phase = PH_SETTLE;
            end else begin
               pulse    = 1'b1;
               mv_phase = PH_MOVE;
            end
         end
      end else if (mv_phase == PH_MOVE) begin
         if (tick_count != 16'hFFFF)
            tick_count = tick_count + 16'd1;
         if (tick_count >= step_half_period()) begin
            tick_count = '0;
            if (!pulse) begin
               pulse = 1'b1;
            end else begin
               // falling edge closes the step and advances each curve that is active on it
               pulse = 1'b0;
               if (step_no < cfg.ramp_up_steps)
                  accel_acc = ratio_mult(accel_acc, {1'b0, cfg.accel_ratio});
               if (18'(step_no) + 18'd1 + 18'(cfg.ramp_down_steps) >
                   18'(cfg.steps_per_move))
                  decel_acc = ratio_mult(decel_acc, cfg.decel_ratio);
               step_no = step_no + 16'd1;
               if (step_no >= cfg.steps_per_move) begin
                  mv_phase     = PH_SETTLE;
                  settle_count = '0;
               end
            end
         end
      end else if (mv_phase == PH_SETTLE) begin
         if (settle_count != 24'hFFFFFF)
            settle_count = settle_count + 24'd1;
         if (settle_count >= cfg.settle_ticks) begin
            if (r.position_ok) begin
               ready_flag = 1'b1;
               mv_phase   = PH_IDLE;
            end else begin
               alarm_flag = 1'b1;
               ready_flag = 1'b0;
               mv_phase   = PH_HALT;
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
         expected_status.delete();
      end else begin
         if (csr_valid && csr_ready)
            write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            advance_motion(req_data);
            // busy taken from the phase just computed, not from the continuous output
            expected_status.push_back(rsp_type'{
               step_level: pulse,
               busy_res:   (mv_phase == PH_MOVE) || (mv_phase == PH_SETTLE),
               ready_res:  ready_flag,
               alarm:      alarm_flag});
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               oldest = expected_status.pop_front();
               check_field("step_level", oldest.step_level, rsp_data.step_level);
               check_field("busy_res", oldest.busy_res, rsp_data.busy_res);
               check_field("ready_res", oldest.ready_res, rsp_data.ready_res);
               check_field("alarm", oldest.alarm, rsp_data.alarm);
               checked++;
            end
         end
      end
      pending = expected_status.size();
   end

endmodule

// ===== test/stepper_exponential_ramp_move_top_tb.sv =====
// testbench top for the ramp move block: drives requests, registers and stalls, gives the verdict
`timescale 1ns / 100ps

module stepper_exponential_ramp_move_top_tb;
   import serm_pkg::*;

   localparam int NUM_REGS       = 8;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   fail_count;
   int   pending;
   int   checked;
   logic move_busy;
   logic sample_due;

   int   items_sent     = 0;
   int   starts_sent    = 0;
   int   settings_used  = 0;
   int   idle_cycles    = 0;
   bit   steady         = 1'b0;

   stepper_exponential_ramp_move_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ramp_move_checker move_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .move_busy  (move_busy),
      .sample_due (sample_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly back to back (always while steady), sometimes a short pause, rarely a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic cfg_type pack_settings(input int steps, input int acc, input int dec,
                                             input int lo, input int hi, input int aratio,
                                             input int dratio, input int settle);
      cfg_type c;
      c.steps_per_move  = 16'(steps);
      c.ramp_up_steps   = 16'(acc);
      c.ramp_down_steps = 16'(dec);
      c.min_half_period = 16'(lo);
      c.max_half_period = 16'(hi);
      c.accel_ratio     = 16'(aratio);
      c.decel_ratio     = 17'(dratio);
      c.settle_ticks    = 24'(settle);
      return c;
   endfunction

   // short moves so that many of them fit into the run
   function automatic cfg_type rand_settings();
      cfg_type c;
      int      r;
      r = $urandom_range(0, 19);
      if (r == 0)
         c.steps_per_move = 16'd0;
      else if (r < 14)
         c.steps_per_move = 16'($urandom_range(1, 4));
      else
         c.steps_per_move = 16'($urandom_range(5, 12));
      c.ramp_up_steps   = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
      c.ramp_down_steps = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
      c.min_half_period = 16'($urandom_range(1, 4));
      c.max_half_period = 16'($urandom_range(1, 6));
      r = $urandom_range(0, 9);
      c.accel_ratio = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
      r = $urandom_range(0, 9);
      c.decel_ratio = (r == 0) ? 17'h10000 : (r == 1) ? 17'h1FFFF :
                      17'($urandom_range(65536, 131071));
      c.settle_ticks = 24'($urandom_range(0, 4));
      // widest upper bound, kept short by a flat curve at the minimum
      if ($urandom_range(0, 7) == 0) begin
         c.max_half_period = 16'hFFFF;
         c.ramp_up_steps   = 16'd0;
         c.decel_ratio     = 17'h10000;
      end
      return c;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(input cfg_type c,
                                                      input logic [CSR_IDX_W-1:0] idx);
      case (idx)
         CSR_STEPS_PER_MOVE:  return CSR_DATA_W'(c.steps_per_move);
         CSR_RAMP_UP_STEPS:   return CSR_DATA_W'(c.ramp_up_steps);
         CSR_RAMP_DOWN_STEPS: return CSR_DATA_W'(c.ramp_down_steps);
         CSR_MIN_HALF_PERIOD: return CSR_DATA_W'(c.min_half_period);
         CSR_MAX_HALF_PERIOD: return CSR_DATA_W'(c.max_half_period);
         CSR_ACCEL_RATIO:     return CSR_DATA_W'(c.accel_ratio);
         CSR_DECEL_RATIO:     return CSR_DATA_W'(c.decel_ratio);
         CSR_SETTLE_TICKS:    return CSR_DATA_W'(c.settle_ticks);
         default:             return '0;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the request is taken
   task automatic send_req(input logic kind, input logic pos_ok);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'{kind: kind, position_ok: pos_ok};
      items_sent++;
      if (kind == KIND_START)
         starts_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drain every response, then give the two-stage pipeline time to empty
   task automatic settle_down();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic load_settings(input cfg_type c);
      settle_down();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= reg_value(c, CSR_IDX_W'(i));
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // one full move; verdict_ok is the position input on the sampling tick
   task automatic run_move(input logic verdict_ok);
      send_req(KIND_START, 1'($urandom_range(0, 1)));
      while (move_busy) begin
         if ($urandom_range(0, 29) == 0)
            send_req(KIND_START, 1'($urandom_range(0, 1)));
         else
            send_req(KIND_TICK, sample_due ? verdict_ok : 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         int hold;
         hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int base;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ticks while idle do nothing
      send_req(KIND_TICK, 1'b0);
      send_req(KIND_TICK, 1'b1);

      // short ramp with a second start while moving
      load_settings(pack_settings(3, 1, 1, 1, 3, 32768, 131071, 2));
      send_req(KIND_START, 1'b0);
      send_req(KIND_START, 1'b1);
      while (move_busy)
         send_req(KIND_TICK, 1'b1);

      // zero steps and zero settle ticks
      load_settings(pack_settings(0, 0, 0, 1, 1, 0, 65536, 0));
      run_move(1'b1);

      // minimum above maximum, both curves longer than the move
      load_settings(pack_settings(1, 65535, 65535, 2, 1, 65535, 65536, 1));
      run_move(1'b1);

      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) < 4)
            load_settings(rand_settings());
         repeat ($urandom_range(0, 3))
            send_req(KIND_TICK, 1'($urandom_range(0, 1)));
         run_move(1'b1);
      end
      steady = 1'b0;

      // wrong position after settle latches the alarm for the rest of the run
      load_settings(rand_settings());
      run_move(1'b0);

      // halted: extreme registers and further requests change nothing
      load_settings(pack_settings(65535, 65535, 65535, 65535, 65535, 65535, 131071, 16777215));
      repeat (30)
         send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("run covered %0d requests (%0d starts) under %0d register settings",
               items_sent, starts_sent, settings_used);
      $display("%0d responses compared, ending with the position alarm latched", checked);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
